/* sv/brrq_pkg.sv */
// shared types and constants of the byte ring record queue
// transaction structs, status codes, defaults; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package brrq_pkg;

  // default sizing
  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_MAX_RECORD = 64;
  localparam int CMDQ_DEPTH     = 4;

  // field widths fixed by the interface
  localparam int CAP_W  = 9;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_record;
    logic [LEN_W-1:0]  record_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] data_byte_out;
    logic              last;
    logic [CAP_W-1:0]  fill_level;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic              is_deq;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              len_ok;
    logic              by_term;
    logic [LEN_W-1:0]  length;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/brrq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module brrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/brrq_front.sv */
// front end: takes input transactions, classifies them, queues commands
// depends on brrq_pkg
`timescale 1ns / 1ps
`default_nettype none

module brrq_front #(
  parameter int MAX_RECORD = brrq_pkg::DEF_MAX_RECORD
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire brrq_pkg::in_item_t in_item,
  output logic                    busy,
  output brrq_pkg::cmd_t          head,
  output logic                    head_valid,
  input  wire logic               pop
);

  import brrq_pkg::*;

  localparam int QA_W = $clog2(CMDQ_DEPTH);
  localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t            q_r [CMDQ_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] count_r;
  logic            push;
  cmd_t            cmd;

  // classification
  always_comb begin
    cmd.is_deq  = (in_item.operation == OP_DEQ);
    cmd.data    = in_item.data_byte;
    cmd.first   = in_item.first_of_record;
    cmd.by_term = (in_item.record_length == '0);
    cmd.len_ok  = (in_item.record_length != '0) &&
                  (in_item.record_length <= LEN_W'(MAX_RECORD));
    if (cmd.is_deq && !cmd.len_ok) begin
      cmd.length = LEN_W'(MAX_RECORD);
    end else begin
      cmd.length = in_item.record_length;
    end
  end

  assign busy       = (count_r == QC_W'(CMDQ_DEPTH));
  assign push       = start && !busy;
  assign head       = q_r[rd_ptr_r];
  assign head_valid = (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QA_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QA_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QC_W'(push) - QC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

/* sv/brrq_back.sv */
// back end: ring pointers, fill count, admission and record dequeue
// depends on brrq_pkg and brrq_ram
`timescale 1ns / 1ps
`default_nettype none

module brrq_back #(
  parameter int CAPACITY = brrq_pkg::DEF_CAPACITY
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [brrq_pkg::CAP_W-1:0] cfg_wr_data,
  input  wire brrq_pkg::cmd_t             head,
  input  wire logic                       head_valid,
  output logic                            pop,
  output logic                            out_valid,
  output brrq_pkg::out_item_t             out_item
);

  import brrq_pkg::*;

  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = ((ADDR_W > CAP_W) ? ADDR_W : CAP_W) + 1;
  localparam int RING_MAX = (CAPACITY > 511) ? 511 : CAPACITY;

  typedef enum logic {S_IDLE, S_DEQ} state_t;

  state_t            state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [ADDR_W-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CAP_W-1:0]  held_r, held_nxt;
  logic              adm_r, adm_nxt;
  logic [LEN_W-1:0]  limit_r, limit_nxt, cnt_r, cnt_nxt;
  logic              by_term_r, by_term_nxt;
  logic              out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [CAP_W-1:0]  ring;
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              adm_now, fits, stop;

  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] pos,
                                               input logic [CAP_W-1:0] rsize);
    logic [CMP_W-1:0] nxt;
    nxt = CMP_W'(pos) + 1'b1;
    return (nxt >= CMP_W'(rsize)) ? '0 : ADDR_W'(nxt);
  endfunction

  // effective ring size: zero means one byte, clamp to the store
  always_comb begin
    if (cap_r == '0) begin
      ring = CAP_W'(1);
    end else if (32'(cap_r) > CAPACITY) begin
      ring = CAP_W'(RING_MAX);
    end else begin
      ring = cap_r;
    end
  end

  assign pop     = (state_r == S_IDLE) && head_valid;
  assign rd_addr = (state_r == S_DEQ) ? advance(rp_r, ring) : rp_r;

  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    adm_nxt       = adm_r;
    limit_nxt     = limit_r;
    cnt_nxt       = cnt_r;
    by_term_nxt   = by_term_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    fits          = ({1'b0, held_r} + (CAP_W + 1)'(head.length)) <= {1'b0, ring};
    adm_now       = head.first ? (head.len_ok && fits) : adm_r;
    stop          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          if (!head.is_deq) begin
            adm_nxt               = adm_now;
            out_valid_nxt         = 1'b1;
            out_nxt.data_byte_out = '0;
            out_nxt.last          = 1'b1;
            out_nxt.status        = ST_REJECT;
            out_nxt.fill_level    = held_r;
            if (adm_now && (held_r < ring)) begin
              wr_en              = 1'b1;
              wp_nxt             = advance(wp_r, ring);
              held_nxt           = held_r + 1'b1;
              out_nxt.status     = ST_OK;
              out_nxt.fill_level = held_r + 1'b1;
            end
          end else if (held_r == '0) begin
            out_valid_nxt         = 1'b1;
            out_nxt.status        = ST_EMPTY;
            out_nxt.data_byte_out = '0;
            out_nxt.last          = 1'b1;
            out_nxt.fill_level    = '0;
          end else begin
            // ram read of the first byte is issued this cycle
            limit_nxt   = head.length;
            by_term_nxt = head.by_term;
            cnt_nxt     = '0;
            state_nxt   = S_DEQ;
          end
        end
      end
      S_DEQ: begin
        stop = (by_term_r && (rd_data == '0)) || (held_r == CAP_W'(1)) ||
               ((cnt_r + 1'b1) >= limit_r);
        rp_nxt                = advance(rp_r, ring);
        held_nxt              = held_r - 1'b1;
        cnt_nxt               = cnt_r + 1'b1;
        out_valid_nxt         = 1'b1;
        out_nxt.status        = ST_OK;
        out_nxt.data_byte_out = rd_data;
        out_nxt.last          = stop;
        out_nxt.fill_level    = held_r - 1'b1;
        if (stop) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a capacity write empties the ring
    if (cfg_wr_en) begin
      rp_nxt   = '0;
      wp_nxt   = '0;
      held_nxt = '0;
      adm_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cap_r     <= CAP_W'(256);
      rp_r      <= '0;
      wp_r      <= '0;
      held_r    <= '0;
      adm_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rp_r      <= rp_nxt;
      wp_r      <= wp_nxt;
      held_r    <= held_nxt;
      adm_r     <= adm_nxt;
      out_valid <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
    limit_r   <= limit_nxt;
    cnt_r     <= cnt_nxt;
    by_term_r <= by_term_nxt;
    out_r     <= out_nxt;
  end

  assign out_item = out_r;

  brrq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (head.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= ring)
    else $error("fill count exceeds ring size");
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CMP_W'(rp_r) < CMP_W'(ring)) && (CMP_W'(wp_r) < CMP_W'(ring)))
    else $error("ring pointer beyond wrap point");
  a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_EMPTY)) |-> (out_item.last &&
      (out_item.fill_level == '0)))
    else $error("empty answer malformed");
  a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ) |-> (held_r != '0))
    else $error("dequeue running on empty ring");
`endif

endmodule

`default_nettype wire

/* sv/byte_ring_record_queue_top.sv */
// top level of the byte ring record queue
// depends on brrq_pkg, brrq_front, brrq_back (and brrq_ram below it)
`timescale 1ns / 1ps
`default_nettype none

//  channel   ports                         handshake
//  input     start, busy, in_item          taken when start && !busy
//  result    out_valid, out_item           one-cycle strobe, always taken
//  config    cfg_wr_en, cfg_wr_data        written when cfg_wr_en
//
//  the front takes one transaction per cycle while its 4-entry command queue
//  has room; busy is simply "queue full"
//  the back retires an enqueue straight from idle; a dequeue first issues
//  the registered ram read, then gives one byte per cycle, with no stall
//  at the earliest a result passes the command queue and the output register
//  (enqueue, empty dequeue); a dequeue's first byte also passes the ram read
//  synchronous active-low reset empties the ring and sets capacity to 256
//  the receiver cannot stall, so results never wait

module byte_ring_record_queue_top #(
  parameter int CAPACITY   = brrq_pkg::DEF_CAPACITY,
  parameter int MAX_RECORD = brrq_pkg::DEF_MAX_RECORD
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire brrq_pkg::in_item_t         in_item,
  output logic                            busy,
  output logic                            out_valid,
  output brrq_pkg::out_item_t             out_item,
  input  wire logic                       cfg_wr_en,
  input  wire logic [brrq_pkg::CAP_W-1:0] cfg_wr_data
);

  import brrq_pkg::*;

  // command queue head between front and back
  cmd_t head;
  logic head_valid;
  logic pop;

  // classify and queue incoming transactions
  brrq_front #(
    .MAX_RECORD (MAX_RECORD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // ring store, admission and record dequeue
  brrq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

/* verif/brrq_checker.sv */
// checker for the byte ring record queue: watches the three channels, predicts every result
// and compares it with what the block emits; depends on brrq_pkg only
`timescale 1ns / 1ps

module brrq_checker
  import brrq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output int               fail_cnt,
  output int               owed_cnt
);

  localparam int RA_W = $clog2(DEF_CAPACITY);

  // predicted ring contents and bookkeeping
  logic [BYTE_W-1:0] ring_mem [DEF_CAPACITY];
  int unsigned       rd_at;
  int unsigned       wr_at;
  int unsigned       held;
  bit                admitted;
  logic [CAP_W-1:0]  cap_reg;
  out_item_t         owed_q [$];

  function automatic int unsigned ring_len();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEF_CAPACITY) return DEF_CAPACITY;
    return 32'(cap_reg);
  endfunction

  function automatic int unsigned step_pos(int unsigned p);
    return (p + 1 >= ring_len()) ? 0 : p + 1;
  endfunction

  task automatic empty_ring();
    rd_at    = 0;
    wr_at    = 0;
    held     = 0;
    admitted = 1'b0;
  endtask

  task automatic owe(logic [1:0] st, logic [BYTE_W-1:0] b, logic lst);
    out_item_t r;
    r.status        = st;
    r.data_byte_out = b;
    r.last          = lst;
    r.fill_level    = held[CAP_W-1:0];
    owed_q.push_back(r);
  endtask

  task automatic ring_take_byte(in_item_t it);
    logic [1:0] st;
    st = ST_REJECT;
    if (it.first_of_record)
      admitted = (it.record_length != 0) && (it.record_length <= DEF_MAX_RECORD) &&
                 (held + it.record_length <= ring_len());
    if (admitted && held < ring_len()) begin
      ring_mem[wr_at[RA_W-1:0]] = it.data_byte;
      wr_at = step_pos(wr_at);
      held++;
      st = ST_OK;
    end
    owe(st, '0, 1'b1);
  endtask

  task automatic ring_give_record(logic [LEN_W-1:0] len);
    int unsigned       limit;
    int unsigned       n;
    logic [BYTE_W-1:0] b;
    bit                by_term;
    bit                stop;
    by_term = (len == 0);
    limit = by_term ? DEF_MAX_RECORD : (len > DEF_MAX_RECORD ? DEF_MAX_RECORD : len);
    if (held == 0) begin
      owe(ST_EMPTY, '0, 1'b1);
      return;
    end
    n    = 0;
    stop = 1'b0;
    while (!stop) begin
      b     = ring_mem[rd_at[RA_W-1:0]];
      rd_at = step_pos(rd_at);
      held--;
      n++;
      stop = (by_term && b == 0) || held == 0 || n >= limit;
      owe(ST_OK, b, stop);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      empty_ring();
      cap_reg  = CAP_W'(DEF_CAPACITY);
      owed_q.delete();
      fail_cnt = 0;
    end else begin
      if (out_valid) begin
        if (owed_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result with nothing expected: status %0d byte %02h last %0d fill %0d",
                     $realtime, out_item.status, out_item.data_byte_out, out_item.last,
                     out_item.fill_level);
        end else begin
          want = owed_q.pop_front();
          if (want.status !== out_item.status || want.data_byte_out !== out_item.data_byte_out ||
              want.last !== out_item.last || want.fill_level !== out_item.fill_level) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"%0t: mismatch (exp/got) status %0d/%0d byte %02h/%02h",
                        " last %0d/%0d fill %0d/%0d"}, $realtime,
                       want.status, out_item.status, want.data_byte_out, out_item.data_byte_out,
                       want.last, out_item.last, want.fill_level, out_item.fill_level);
          end
        end
      end
      if (cfg_wr_en) begin
        cap_reg = cfg_wr_data;
        empty_ring();
      end
      if (start && !busy) begin
        if (in_item.operation == OP_ENQ) ring_take_byte(in_item);
        else ring_give_record(in_item.record_length);
      end
    end
    owed_cnt <= owed_q.size();
  end

endmodule

/* verif/tb.sv */
// testbench top for the byte ring record queue: clock, reset, stimulus and verdict
// depends on brrq_pkg, brrq_checker and the block's RTL
`timescale 1ns / 1ps

module tb;
  import brrq_pkg::*;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             start       = 1'b0;
  in_item_t         in_item     = '0;
  logic             cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic             busy;
  logic             out_valid;
  out_item_t        out_item;
  int               fail_cnt;
  int               owed_cnt;

  // random gaps between transactions are allowed while this is set
  bit               idle_en     = 1'b1;
  int unsigned      sent        = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_ring_record_queue_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // the checker sees exactly what the block sees and predicts on its own
  brrq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_cnt   (fail_cnt),
    .owed_cnt   (owed_cnt)
  );

  // hand one transaction to the block, optionally after a short idle burst;
  // returns in the time step of the edge that accepted it, with start still high
  task automatic put(logic op, logic [BYTE_W-1:0] b, logic fst, logic [LEN_W-1:0] len);
    in_item_t it;
    it.operation       = op;
    it.data_byte       = b;
    it.first_of_record = fst;
    it.record_length   = len;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // one record, announced length and bytes actually sent may differ;
  // half the records end in a zero terminator with no zero before it
  task automatic send_record(int unsigned announced, int unsigned actual);
    logic [BYTE_W-1:0] b;
    bit                term;
    term = 1'($urandom_range(0, 1));
    for (int i = 0; i < actual; i++) begin
      b = BYTE_W'($urandom_range(0, 255));
      if (term) b = (i == actual - 1) ? 8'h00 : (b == 0 ? 8'h01 : b);
      put(OP_ENQ, b, i == 0, i == 0 ? announced[LEN_W-1:0] : LEN_W'($urandom_range(0, 127)));
    end
  endtask

  task automatic dequeue(logic [LEN_W-1:0] len);
    put(OP_DEQ, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len);
  endtask

  // mostly short records that suit the ring, sometimes anything up to the max
  function automatic int unsigned pick_len(int unsigned ring);
    int unsigned top;
    top = (ring < 8) ? ring : 8;
    return ($urandom_range(0, 4) != 0) ? $urandom_range(1, top)
                                       : $urandom_range(1, DEF_MAX_RECORD);
  endfunction

  // stop feeding, then wait until every predicted result has come out
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (owed_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // capacity write, only ever done with the block idle
  task automatic set_capacity(logic [CAP_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int unsigned quota, int unsigned ring);
    int unsigned stop_at;
    int unsigned r;
    int unsigned len;
    int unsigned n;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // well-formed record
        len = pick_len(ring);
        send_record(len, len);
      end else if (r < 80) begin
        // dequeue: by terminator, short, long, or above the max length
        r = $urandom_range(0, 9);
        if (r < 4)      len = 0;
        else if (r < 7) len = $urandom_range(1, 8);
        else if (r < 9) len = $urandom_range(9, DEF_MAX_RECORD);
        else            len = $urandom_range(DEF_MAX_RECORD + 1, 127);
        dequeue(LEN_W'(len));
      end else if (r < 88) begin
        // record with more or fewer bytes than it announces
        len = pick_len(ring);
        if (len > 1 && $urandom_range(0, 1)) n = $urandom_range(1, len - 1);
        else                                 n = len + $urandom_range(1, 3);
        send_record(len, n);
      end else if (r < 94) begin
        // illegal announced length, record rejected as a whole
        len = $urandom_range(0, 1) ? 0 : $urandom_range(DEF_MAX_RECORD + 1, 127);
        send_record(len, $urandom_range(1, 4));
      end else begin
        // continuation bytes with no record opened
        repeat ($urandom_range(1, 3))
          put(OP_ENQ, BYTE_W'($urandom_range(0, 255)), 1'b0, LEN_W'($urandom_range(0, 127)));
      end
    end
  endtask

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] caps [8];
    logic [CAP_W-1:0] cap;
    caps = '{9'd511, 9'd2, 9'd300, 9'd37, 9'd1, 9'd256, 9'd0, 9'd255};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset capacity of 256
    put(OP_DEQ, 8'h00, 1'b0, 7'd0);     // dequeue on an empty queue
    put(OP_ENQ, 8'h55, 1'b1, 7'd0);     // zero length record
    put(OP_ENQ, 8'hAA, 1'b1, 7'd127);   // length above the max record
    put(OP_ENQ, 8'h12, 1'b0, 7'd3);     // continuation of a record never admitted
    put(OP_ENQ, 8'hFF, 1'b1, 7'd3);
    put(OP_ENQ, 8'h00, 1'b0, 7'd0);
    put(OP_ENQ, 8'hA5, 1'b0, 7'd0);
    put(OP_ENQ, 8'h01, 1'b1, 7'd2);
    put(OP_ENQ, 8'h7E, 1'b0, 7'd0);
    put(OP_DEQ, 8'hFF, 1'b1, 7'd0);     // stops on the zero terminator
    put(OP_DEQ, 8'h00, 1'b0, 7'd127);   // length saturates, runs the queue dry
    put(OP_DEQ, 8'h00, 1'b0, 7'd1);     // empty again
    put(OP_ENQ, 8'h11, 1'b1, 7'd2);     // record longer than announced
    put(OP_ENQ, 8'h22, 1'b0, 7'd0);
    put(OP_ENQ, 8'h33, 1'b0, 7'd0);
    put(OP_ENQ, 8'h80, 1'b1, 7'd64);    // max length fits, left unfinished
    put(OP_DEQ, 8'h00, 1'b0, 7'd64);
    settle();

    // capacity register zero means a one-byte ring
    set_capacity(9'd0);
    put(OP_ENQ, 8'h5A, 1'b1, 7'd1);
    put(OP_ENQ, 8'h3C, 1'b0, 7'd0);     // ring full inside an admitted record
    put(OP_ENQ, 8'h6B, 1'b1, 7'd2);     // does not fit
    put(OP_DEQ, 8'h00, 1'b0, 7'd0);     // no terminator, stops when empty
    put(OP_DEQ, 8'h00, 1'b0, 7'd0);
    settle();

    // random phases over several capacities, the last one without gaps
    for (int p = 0; p < 8; p++) begin
      cap = (p == 6) ? CAP_W'($urandom_range(3, DEF_CAPACITY)) : caps[p];
      idle_en = (p != 7);
      set_capacity(cap);
      random_phase(40, cap == 0 ? 1 : (cap > DEF_CAPACITY ? DEF_CAPACITY : cap));
      settle();
    end

    if (fail_cnt == 0 && owed_cnt == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
